// ===== rtl/keypad_code_lock_defines.svh =====
// keypad_code_lock_defines.svh: assertion macros used by keypad_code_lock.sv.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef KEYPAD_CODE_LOCK_DEFINES_SVH
`define KEYPAD_CODE_LOCK_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define KCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kcl_pkg.sv =====
// kcl_pkg.sv: shared types and constants of the keypad code lock.
// No dependencies.
`timescale 1ns / 1ps

package kcl_pkg;

    // Default number of keys in one entry
    localparam int KCL_CODE_LENGTH = 6;

    // Key code that means no key was pressed
    localparam logic [7:0] KCL_NO_KEY = 8'hff;

    // Result event codes
    typedef enum logic [2:0] {
        EV_DIGIT      = 3'd0,
        EV_FIRST_DONE = 3'd1,
        EV_ENROLLED   = 3'd2,
        EV_MISMATCH   = 3'd3,
        EV_GRANTED    = 3'd4,
        EV_REFUSED    = 3'd5
    } kcl_event_t;

endpackage

// ===== rtl/keypad_code_lock.sv =====
// keypad_code_lock.sv: keypad code lock with code enrollment (top level).
// Depends on kcl_pkg.sv and keypad_code_lock_defines.svh.
// Input channel: in_valid/in_ready with key_code. A key code of 0xff means
// no key; it is taken and dropped without a result and changes nothing.
// Output channel: out_valid/out_ready with event_res and position; every
// other key gives exactly one item. Until a code is enrolled, two entries of
// CODE_LENGTH keys are collected and compared (enrolled or mismatch); after
// that each entry is checked against the stored code (granted or refused).
// A key is registered in the input register, and its result is then
// registered in the output register, which drives out_valid.
// Throughput: one key per cycle unless the receiver stalls; the entry
// update and the parallel compare of all CODE_LENGTH keys fit between the
// input and output registers.
// Reset clears the enrolled mark and the key count; the entry stores are not
// cleared and are always written before they are read.
// When the receiver stalls, the result holds in the output register and one
// more key waits in the input register; in_ready then drops until out_ready.
`timescale 1ns / 1ps
`include "keypad_code_lock_defines.svh"

module keypad_code_lock
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = KCL_CODE_LENGTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] key_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [2:0] position
);

    localparam int CNT_MAX = 2 * CODE_LENGTH;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam logic [CNT_W-1:0] LEN         = CNT_W'(CODE_LENGTH);
    localparam logic [CNT_W-1:0] LAST_FIRST  = CNT_W'(CODE_LENGTH - 1);
    localparam logic [CNT_W-1:0] LAST_SECOND = CNT_W'(CNT_MAX - 1);

    // Input register
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       key_reg;

    // Lock state
    logic             enrolled_reg, enrolled_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       first_reg  [CODE_LENGTH];
    logic [7:0]       second_reg [CODE_LENGTH];
    logic [7:0]       stored_reg [CODE_LENGTH];

    // Output register
    logic             out_valid_reg, out_valid_next;
    kcl_event_t       event_reg, event_next;
    logic [2:0]       pos_reg, pos_next;

    // Processing signals
    logic             proc_fire;
    logic             in_second;
    logic             last_key;
    logic [CNT_W-1:0] pos;
    logic             match_stored;
    logic             match_first;

    // Handshake: the input register moves on whenever the output register
    // is free or being emptied
    assign proc_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc_fire;

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign position  = pos_reg;

    // Where the current key goes
    always_comb
    begin
        in_second = !enrolled_reg && (count_reg >= LEN);
        if (in_second)
        begin
            pos      = count_reg - LEN;
            last_key = (count_reg == LAST_SECOND);
        end
        else
        begin
            pos      = count_reg;
            last_key = (count_reg == LAST_FIRST);
        end
    end

    // Full-entry compares, with the current key as the last one
    always_comb
    begin
        match_stored = 1'b1;
        match_first  = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (i == CODE_LENGTH - 1)
            begin
                if (key_reg != stored_reg[i]) match_stored = 1'b0;
                if (key_reg != first_reg[i])  match_first  = 1'b0;
            end
            else
            begin
                if (first_reg[i] != stored_reg[i]) match_stored = 1'b0;
                if (second_reg[i] != first_reg[i]) match_first  = 1'b0;
            end
        end
    end

    // Next state and result
    always_comb
    begin
        enrolled_next = enrolled_reg;
        count_next    = count_reg;
        event_next    = event_reg;
        pos_next      = pos_reg;
        if (proc_fire)
        begin
            pos_next   = 3'(pos);
            event_next = EV_DIGIT;
            if (last_key)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
            if (enrolled_reg)
            begin
                if (last_key)
                begin
                    event_next = match_stored ? EV_GRANTED : EV_REFUSED;
                end
            end
            else if (in_second)
            begin
                if (last_key)
                begin
                    event_next    = match_first ? EV_ENROLLED : EV_MISMATCH;
                    enrolled_next = match_first;
                end
            end
            else
            begin
                if (last_key)
                begin
                    // first entry complete: keep counting into the second
                    event_next = EV_FIRST_DONE;
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    // Valid flags of both registers
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid && (key_code != KCL_NO_KEY);
        end
        out_valid_next = out_valid_reg;
        if (proc_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enrolled_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            enrolled_reg  <= enrolled_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            key_reg <= key_code;
        end
        event_reg <= event_next;
        pos_reg   <= pos_next;
    end

    // Entry stores
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (proc_fire && !in_second && pos == CNT_W'(i))
            begin
                first_reg[i] <= key_reg;
            end
            if (proc_fire && in_second && pos == CNT_W'(i))
            begin
                second_reg[i] <= key_reg;
            end
            if (proc_fire && in_second && last_key && match_first)
            begin
                stored_reg[i] <= first_reg[i];
            end
        end
    end

    // Checks
    `KCL_ASSERT_NOW(a_count_range, 1'b1, count_reg <= LAST_SECOND, "key count out of range")
    `KCL_ASSERT_NOW(a_count_enrolled, enrolled_reg, count_reg <= LAST_FIRST, "count past entry while enrolled")
    `KCL_ASSERT_NOW(a_end_position, out_valid_reg && event_reg != EV_DIGIT, pos_reg == 3'(CODE_LENGTH - 1), "entry end at wrong position")
    `KCL_ASSERT_NOW(a_enroll_event, $rose(enrolled_reg), out_valid_reg && event_reg == EV_ENROLLED, "enrolled without enrolled event")

endmodule

// ===== verif/keypad_code_lock_test.sv =====
`timescale 1ns / 1ps
// keypad_code_lock_test.sv: self-checking testbench for the keypad code lock.
// Depends on kcl_pkg.sv and the keypad_code_lock RTL. It drives keys and keeps
// its own model of the lock, then checks every result item in order.

module keypad_code_lock_test;
    import kcl_pkg::*;

    localparam int CODE_LEN      = KCL_CODE_LENGTH;
    localparam int KEY_TARGET    = 1550;
    localparam int DIR_ROWS      = 25;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        kcl_event_t ev;
        logic [2:0] pos;
    } lock_result_t;

    // One row of the directed table; pinned rows carry a hand-written result
    typedef struct packed {
        logic [7:0] key;
        logic       pinned;
        kcl_event_t ev;
        logic [2:0] pos;
    } key_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] key_code;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] event_res;
    logic [2:0] position;

    // Lock model state
    logic        lock_enrolled;
    int unsigned key_count;
    logic [7:0]  entry_a   [CODE_LEN];
    logic [7:0]  entry_b   [CODE_LEN];
    logic [7:0]  code_keys [CODE_LEN];

    lock_result_t pending_results [$];
    int  error_count = 0;
    int  keys_sent = 0;
    int  idle_sent = 0;
    int  results_seen [6] = '{default: 0};
    bit  tx_calm = 1'b0;

    // Enrollment with a mismatch in the last key only, a no-key code inside
    // the second entry, then a good enrollment of the code used afterwards.
    key_row_t key_table [DIR_ROWS] = '{
        '{8'h00, 1'b1, EV_DIGIT,      3'd0},
        '{8'hfe, 1'b0, EV_DIGIT,      3'd0},
        '{8'h80, 1'b0, EV_DIGIT,      3'd0},
        '{8'h7f, 1'b0, EV_DIGIT,      3'd0},
        '{8'h01, 1'b0, EV_DIGIT,      3'd0},
        '{8'h55, 1'b1, EV_FIRST_DONE, 3'd5},
        '{8'h00, 1'b1, EV_DIGIT,      3'd0},
        '{8'hfe, 1'b0, EV_DIGIT,      3'd0},
        '{8'h80, 1'b0, EV_DIGIT,      3'd0},
        '{8'hff, 1'b0, EV_DIGIT,      3'd0},
        '{8'h7f, 1'b0, EV_DIGIT,      3'd0},
        '{8'h01, 1'b0, EV_DIGIT,      3'd0},
        '{8'h54, 1'b1, EV_MISMATCH,   3'd5},
        '{8'h00, 1'b1, EV_DIGIT,      3'd0},
        '{8'hfe, 1'b0, EV_DIGIT,      3'd0},
        '{8'h80, 1'b0, EV_DIGIT,      3'd0},
        '{8'h7f, 1'b0, EV_DIGIT,      3'd0},
        '{8'h01, 1'b0, EV_DIGIT,      3'd0},
        '{8'h55, 1'b1, EV_FIRST_DONE, 3'd5},
        '{8'h00, 1'b0, EV_DIGIT,      3'd0},
        '{8'hfe, 1'b0, EV_DIGIT,      3'd0},
        '{8'h80, 1'b0, EV_DIGIT,      3'd0},
        '{8'h7f, 1'b0, EV_DIGIT,      3'd0},
        '{8'h01, 1'b0, EV_DIGIT,      3'd0},
        '{8'h55, 1'b1, EV_ENROLLED,   3'd5}
    };

    keypad_code_lock u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key_code  (key_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .event_res (event_res),
        .position  (position)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly back to back, some short pauses, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_key();
        return 8'($urandom_range(0, 254));
    endfunction

    // Lock model: one accepted key in, the expected result out
    function automatic void predict_key(input logic [7:0] key, output kcl_event_t ev,
                                        output logic [2:0] pos);
        int unsigned idx;
        bit          same;
        ev   = EV_DIGIT;
        same = 1'b1;
        if (!lock_enrolled)
        begin
            if (key_count < CODE_LEN)
            begin
                idx = key_count;
                entry_a[idx] = key;
                key_count++;
                if (key_count == CODE_LEN)
                    ev = EV_FIRST_DONE;
            end
            else
            begin
                idx = key_count - CODE_LEN;
                entry_b[idx] = key;
                key_count++;
                if (key_count == 2 * CODE_LEN)
                begin
                    key_count = 0;
                    for (int i = 0; i < CODE_LEN; i++)
                        if (entry_a[i] != entry_b[i])
                            same = 1'b0;
                    if (same)
                    begin
                        code_keys     = entry_a;
                        lock_enrolled = 1'b1;
                        ev            = EV_ENROLLED;
                    end
                    else
                        ev = EV_MISMATCH;
                end
            end
        end
        else
        begin
            idx = key_count;
            entry_a[idx] = key;
            key_count++;
            if (key_count == CODE_LEN)
            begin
                key_count = 0;
                for (int i = 0; i < CODE_LEN; i++)
                    if (entry_a[i] != code_keys[i])
                        same = 1'b0;
                ev = same ? EV_GRANTED : EV_REFUSED;
            end
        end
        pos = idx[2:0];
    endfunction

    // Offer one item, wait for it to be taken, then queue its result if it is a key
    task automatic offer_item(input logic [7:0] key, input logic pinned,
                              input kcl_event_t pin_ev, input logic [2:0] pin_pos);
        int           gap;
        kcl_event_t   ev;
        logic [2:0]   pos;
        lock_result_t r;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_code <= key;
        do
            @(posedge clk);
        while (!in_ready);
        if (key == KCL_NO_KEY)
            idle_sent++;
        else
        begin
            keys_sent++;
            predict_key(key, ev, pos);
            r.ev  = pinned ? pin_ev : ev;
            r.pos = pinned ? pin_pos : pos;
            pending_results.push_back(r);
        end
    endtask

    // A key, now and then preceded by a no-key code
    task automatic press(input logic [7:0] key);
        if ($urandom_range(0, 11) == 0)
            offer_item(KCL_NO_KEY, 1'b0, EV_DIGIT, 3'd0);
        offer_item(key, 1'b0, EV_DIGIT, 3'd0);
    endtask

    // Stimulus
    initial
    begin : key_driver
        int         kind;
        int         p;
        logic [7:0] v;
        logic [7:0] entry [CODE_LEN];
        lock_enrolled = 1'b0;
        key_count     = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        key_code <= 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (key_table[i])
            offer_item(key_table[i].key, key_table[i].pinned, key_table[i].ev,
                       key_table[i].pos);

        // Random entries against the enrolled code
        while (keys_sent < KEY_TARGET)
        begin
            tx_calm = ($urandom_range(0, 7) == 0);
            kind    = $urandom_range(0, 99);
            if (kind < 10)
            begin
                // stray keys that shift the entry boundary
                repeat ($urandom_range(1, 5)) press(rand_key());
            end
            else
            begin
                // finish any partial entry so the next one lines up
                while (key_count != 0)
                    press(rand_key());
                entry = code_keys;
                if (kind >= 45 && kind < 75)
                begin
                    // near miss: one key wrong
                    p = $urandom_range(0, CODE_LEN - 1);
                    do
                        v = rand_key();
                    while (v == entry[p]);
                    entry[p] = v;
                end
                else if (kind >= 75)
                begin
                    foreach (entry[i])
                        entry[i] = rand_key();
                end
                foreach (entry[i])
                    press(entry[i]);
            end
        end
        in_valid <= 1'b0;

        // Drain, then let the bench settle to catch stray results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d keys and %0d no-key codes sent, %0d mismatches found",
                 keys_sent, idle_sent, error_count);
        $display("summary: enrolled %0d, enroll mismatch %0d, granted %0d, refused %0d",
                 results_seen[EV_ENROLLED], results_seen[EV_MISMATCH],
                 results_seen[EV_GRANTED], results_seen[EV_REFUSED]);
        if (error_count == 0)
            $display("keypad_code_lock_test: done, clean");
        else
            $display("keypad_code_lock_test: done, errors");
        $finish;
    end

    // Receiver: random back-pressure and in-order checking
    initial
    begin : result_monitor
        int           stall_left;
        int           mode_left;
        bit           rx_calm;
        lock_result_t want;
        stall_left = 0;
        mode_left  = 0;
        rx_calm    = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected item: event_res %0d position %0d", event_res, position);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (event_res !== want.ev)
                    begin
                        $error("event_res: expected %0d, actual %0d", want.ev, event_res);
                        error_count++;
                    end
                    if (position !== want.pos)
                    begin
                        $error("position: expected %0d, actual %0d", want.pos, position);
                        error_count++;
                    end
                    results_seen[int'(want.ev)]++;
                end
            end

            // switch between stretches with and without stalls
            if (mode_left == 0)
            begin
                rx_calm   = ($urandom_range(0, 4) == 0);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;

            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("keypad_code_lock_test: done, errors");
        $finish;
    end

endmodule

// ===== keypad_code_lock.f =====
+incdir+rtl
rtl/kcl_pkg.sv
rtl/keypad_code_lock.sv
verif/keypad_code_lock_test.sv
